/* rtl/core/rti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants for the ray/triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_WIDTH_DEF = 21;
  localparam int FRAC_BITS_DEF   = 11;

  localparam int VEC_W      = 63;
  localparam int DIST_W     = 32;
  localparam int EPS_W      = 10;
  localparam int SUM_GUARD  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 3'd4;

  localparam logic [EPS_W-1:0] EPS_RESET = 10'd1;

endpackage

/* rtl/core/rti_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_in_if / rti_out_if
// Valid/ready channels for rays in and intersection results out.
// ----------------------------------------------------------------------------
interface rti_in_if;
  logic                      valid;
  logic                      ready;
  logic [rti_pkg::VEC_W-1:0]  ray_origin;
  logic [rti_pkg::VEC_W-1:0]  ray_direction;
  logic [rti_pkg::DIST_W-1:0] closest_distance;

  modport source (output valid, ray_origin, ray_direction, closest_distance, input ready);
  modport sink (input valid, ray_origin, ray_direction, closest_distance, output ready);
endinterface

interface rti_out_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [rti_pkg::DIST_W-1:0] hit_distance;
  logic [rti_pkg::VEC_W-1:0]  hit_point;
  logic [rti_pkg::VEC_W-1:0]  hit_normal;

  modport source (output valid, hit, hit_distance, hit_point, hit_normal, input ready);
  modport sink (input valid, hit, hit_distance, hit_point, hit_normal, output ready);
endinterface

/* rtl/core/ray_triangle_intersect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Pipelined Moller-Trumbore ray/triangle test against a configured triangle.
// ----------------------------------------------------------------------------
// Throughput: one ray per cycle; the whole pipe advances together and holds
// only while the output register is full and not taken. Most of the pipe is
// the 32-step restoring divider, one quotient bit per stage.
// Reset (synchronous, rst_n low): all valid bits clear, configuration
// registers go to their reset values (epsilon 1, vectors 0).
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rti_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rti_in_if.sink                         in_ray,
  rti_out_if.source                      out_hit
);

  // Widths of the datapath, all derived from the coordinate width.
  localparam int CW    = COORD_WIDTH;
  localparam int TW    = CW + 1;          // origin minus vertex
  localparam int PW    = 2 * CW + 1;      // D x E2
  localparam int QW    = 2 * CW + 2;      // T x E1
  localparam int MW    = 3 * CW + 2;      // one dot-product term
  localparam int DW    = 3 * CW + 4;      // dot-product sum
  localparam int DL    = rti_pkg::DIST_W;
  localparam int SHW   = DL - FRAC_BITS;
  localparam int NDIV  = DL;
  localparam int CMPW  = DW + 2 * FRAC_BITS + rti_pkg::EPS_W;
  localparam int TPW   = DL + 1 + CW;     // t * direction
  localparam int PTW   = TPW + 1;
  localparam logic signed [PTW-1:0] PT_HI = PTW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [PTW-1:0] PT_LO = -PT_HI - PTW'(1);

  // Configuration registers.
  logic [rti_pkg::VEC_W-1:0] vertex0_r, edge1_r, edge2_r, normal_r;
  logic [rti_pkg::EPS_W-1:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex0_r <= '0;
      edge1_r   <= '0;
      edge2_r   <= '0;
      normal_r  <= '0;
      eps_r     <= rti_pkg::EPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rti_pkg::REG_VERTEX0: vertex0_r <= cfg_wdata;
        rti_pkg::REG_EDGE1:   edge1_r   <= cfg_wdata;
        rti_pkg::REG_EDGE2:   edge2_r   <= cfg_wdata;
        rti_pkg::REG_NORMAL:  normal_r  <= cfg_wdata;
        rti_pkg::REG_EPSILON: eps_r     <= cfg_wdata[rti_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the triangle and the incoming ray into components.
  logic signed [CW-1:0] v0 [3];
  logic signed [CW-1:0] e1 [3];
  logic signed [CW-1:0] e2 [3];
  logic signed [CW-1:0] in_o [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v0[k]   = vertex0_r[k*CW +: CW];
      e1[k]   = edge1_r[k*CW +: CW];
      e2[k]   = edge2_r[k*CW +: CW];
      in_o[k] = in_ray.ray_origin[k*CW +: CW];
    end
  end

  // Global advance: the whole pipe moves unless a result waits at the output and is not taken.
  logic out_v_r;
  logic en;
  assign en           = !out_v_r || out_hit.ready;
  assign in_ray.ready = en;

  // Stage 1: T = O - V0.
  logic                       s1_v_r;
  logic [rti_pkg::VEC_W-1:0]  s1_o_r, s1_d_r;
  logic [DL-1:0]              s1_cl_r;
  logic signed [TW-1:0]       s1_t_r [3];

  // Stage 2: cross-product terms.
  logic                       s2_v_r;
  logic [rti_pkg::VEC_W-1:0]  s2_o_r, s2_d_r;
  logic [DL-1:0]              s2_cl_r;
  logic signed [TW-1:0]       s2_t_r [3];
  logic signed [2*CW-1:0]     s2_pa_r [3], s2_pb_r [3];
  logic signed [2*CW:0]       s2_qa_r [3], s2_qb_r [3];

  // Stage 3: P and Q.
  logic                       s3_v_r;
  logic [rti_pkg::VEC_W-1:0]  s3_o_r, s3_d_r;
  logic [DL-1:0]              s3_cl_r;
  logic signed [TW-1:0]       s3_t_r [3];
  logic signed [PW-1:0]       s3_p_r [3];
  logic signed [QW-1:0]       s3_q_r [3];

  // Stage 4: dot-product terms, each floored by the guard shift.
  logic                       s4_v_r;
  logic [rti_pkg::VEC_W-1:0]  s4_o_r, s4_d_r;
  logic [DL-1:0]              s4_cl_r;
  logic signed [MW-1:0]       s4_det_r [3], s4_un_r [3], s4_vn_r [3], s4_tn_r [3];

  // Stage 5: sums.
  logic                       s5_v_r;
  logic [rti_pkg::VEC_W-1:0]  s5_o_r, s5_d_r;
  logic [DL-1:0]              s5_cl_r;
  logic signed [DW-1:0]       s5_det_r, s5_un_r, s5_vn_r, s5_tn_r;

  // Stage 6: sign fix-up and early rejects.
  logic                       s6_v_r;
  logic [rti_pkg::VEC_W-1:0]  s6_o_r, s6_d_r;
  logic [DL-1:0]              s6_cl_r;
  logic                       s6_rej_r;
  logic [DW-1:0]              s6_adet_r, s6_tn_r;

  // Divider pipe: index 0 is set up from stage 6, index NDIV holds the quotient.
  logic                       dv_v_r    [NDIV+1];
  logic [rti_pkg::VEC_W-1:0]  dv_o_r    [NDIV+1];
  logic [rti_pkg::VEC_W-1:0]  dv_d_r    [NDIV+1];
  logic [DL-1:0]              dv_cl_r   [NDIV+1];
  logic                       dv_rej_r  [NDIV+1];
  logic                       dv_sat_r  [NDIV+1];
  logic [DW-1:0]              dv_adet_r [NDIV+1];
  logic [DW-1:0]              dv_rem_r  [NDIV+1];
  logic [DL-1:0]              dv_low_r  [NDIV+1];
  logic [DL-1:0]              dv_q_r    [NDIV+1];

  // Stage A: final t, late rejects, t * D.
  logic                       sa_v_r;
  logic [rti_pkg::VEC_W-1:0]  sa_o_r;
  logic                       sa_miss_r;
  logic [DL-1:0]              sa_t_r;
  logic signed [TPW-1:0]      sa_prod_r [3];

  // Output register.
  logic                       out_hit_r;
  logic [DL-1:0]              out_dist_r;
  logic [rti_pkg::VEC_W-1:0]  out_pt_r, out_nrm_r;

  // Combinational work in front of each register stage.
  logic signed [MW-1:0]  det_t [3], un_t [3], vn_t [3], tn_t [3];
  logic signed [DW-1:0]  det_s, un_s, vn_s, tn_s;
  logic signed [DW-1:0]  det6, un6, vn6, tn6;
  logic signed [DW:0]    uv_sum;
  logic [CMPW-1:0]       thr;
  logic                  rej6;
  logic [DW-1:0]         trial [NDIV];
  logic                  take  [NDIV];
  logic [DL-1:0]         tfix;
  logic                  miss_a;
  logic signed [CW-1:0]  sa_d [3];
  logic signed [CW-1:0]  sb_o [3];
  logic signed [PTW-1:0] pt_sum [3];
  logic [rti_pkg::VEC_W-1:0] pt_pack;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      det_t[k] = s3_p_r[k] * e1[k];
      un_t[k]  = s3_p_r[k] * s3_t_r[k];
      vn_t[k]  = s3_q_r[k] * $signed(s3_d_r[k*CW +: CW]);
      tn_t[k]  = s3_q_r[k] * e2[k];
    end
    det_s = s4_det_r[0] + s4_det_r[1] + s4_det_r[2];
    un_s  = s4_un_r[0] + s4_un_r[1] + s4_un_r[2];
    vn_s  = s4_vn_r[0] + s4_vn_r[1] + s4_vn_r[2];
    tn_s  = s4_tn_r[0] + s4_tn_r[1] + s4_tn_r[2];

    // Make the determinant positive; flip the numerators with it.
    if (s5_det_r < 0) begin
      det6 = -s5_det_r;
      un6  = -s5_un_r;
      vn6  = -s5_vn_r;
      tn6  = -s5_tn_r;
    end else begin
      det6 = s5_det_r;
      un6  = s5_un_r;
      vn6  = s5_vn_r;
      tn6  = s5_tn_r;
    end
    uv_sum = un6 + vn6;
    thr    = CMPW'(eps_r) << (2 * FRAC_BITS - rti_pkg::SUM_GUARD);
    rej6   = (det6 == '0) || (CMPW'(det6) < thr) || (un6 < 0) || (vn6 < 0) ||
             (uv_sum > $signed({1'b0, det6})) || (tn6 <= 0);

    // One restoring step per divider stage.
    for (int j = 0; j < NDIV; j++) begin
      trial[j] = {dv_rem_r[j][DW-2:0], dv_low_r[j][DL-1]};
      take[j]  = trial[j] >= dv_adet_r[j];
    end

    tfix   = dv_sat_r[NDIV] ? '1 : dv_q_r[NDIV];
    miss_a = dv_rej_r[NDIV] || (tfix <= DL'(eps_r)) ||
             ((dv_cl_r[NDIV] != '1) && (tfix >= dv_cl_r[NDIV]));
    for (int k = 0; k < 3; k++) begin
      sa_d[k] = dv_d_r[NDIV][k*CW +: CW];
      sb_o[k] = sa_o_r[k*CW +: CW];
    end

    // Hit point, saturated per component.
    pt_pack = '0;
    for (int k = 0; k < 3; k++) begin
      pt_sum[k] = sb_o[k] + (sa_prod_r[k] >>> FRAC_BITS);
      if (pt_sum[k] > PT_HI) begin
        pt_sum[k] = PT_HI;
      end else if (pt_sum[k] < PT_LO) begin
        pt_sum[k] = PT_LO;
      end
      pt_pack[k*CW +: CW] = pt_sum[k][CW-1:0];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      sa_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int j = 0; j <= NDIV; j++) begin
        dv_v_r[j] <= 1'b0;
      end
    end else if (en) begin
      s1_v_r    <= in_ray.valid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      s5_v_r    <= s4_v_r;
      s6_v_r    <= s5_v_r;
      dv_v_r[0] <= s6_v_r;
      for (int j = 0; j < NDIV; j++) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      sa_v_r  <= dv_v_r[NDIV];
      out_v_r <= sa_v_r;
    end
  end

  // Payload; advance with the valid bits, hold on a stall.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_o_r  <= in_ray.ray_origin;
      s1_d_r  <= in_ray.ray_direction;
      s1_cl_r <= in_ray.closest_distance;
      for (int k = 0; k < 3; k++) begin
        s1_t_r[k] <= TW'(in_o[k]) - TW'(v0[k]);
      end

      s2_o_r  <= s1_o_r;
      s2_d_r  <= s1_d_r;
      s2_cl_r <= s1_cl_r;
      for (int k = 0; k < 3; k++) begin
        s2_t_r[k]  <= s1_t_r[k];
        s2_pa_r[k] <= $signed(s1_d_r[((k+1)%3)*CW +: CW]) * e2[(k+2)%3];
        s2_pb_r[k] <= $signed(s1_d_r[((k+2)%3)*CW +: CW]) * e2[(k+1)%3];
        s2_qa_r[k] <= s1_t_r[(k+1)%3] * e1[(k+2)%3];
        s2_qb_r[k] <= s1_t_r[(k+2)%3] * e1[(k+1)%3];
      end

      s3_o_r  <= s2_o_r;
      s3_d_r  <= s2_d_r;
      s3_cl_r <= s2_cl_r;
      for (int k = 0; k < 3; k++) begin
        s3_t_r[k] <= s2_t_r[k];
        s3_p_r[k] <= PW'(s2_pa_r[k]) - PW'(s2_pb_r[k]);
        s3_q_r[k] <= QW'(s2_qa_r[k]) - QW'(s2_qb_r[k]);
      end

      s4_o_r  <= s3_o_r;
      s4_d_r  <= s3_d_r;
      s4_cl_r <= s3_cl_r;
      for (int k = 0; k < 3; k++) begin
        s4_det_r[k] <= det_t[k] >>> rti_pkg::SUM_GUARD;
        s4_un_r[k]  <= un_t[k] >>> rti_pkg::SUM_GUARD;
        s4_vn_r[k]  <= vn_t[k] >>> rti_pkg::SUM_GUARD;
        s4_tn_r[k]  <= tn_t[k] >>> rti_pkg::SUM_GUARD;
      end

      s5_o_r   <= s4_o_r;
      s5_d_r   <= s4_d_r;
      s5_cl_r  <= s4_cl_r;
      s5_det_r <= det_s;
      s5_un_r  <= un_s;
      s5_vn_r  <= vn_s;
      s5_tn_r  <= tn_s;

      s6_o_r    <= s5_o_r;
      s6_d_r    <= s5_d_r;
      s6_cl_r   <= s5_cl_r;
      s6_rej_r  <= rej6;
      s6_adet_r <= det6;
      s6_tn_r   <= tn6;

      // Divider setup: saturate when t would not fit, seed the remainder
      // with the high part of the scaled numerator.
      dv_o_r[0]    <= s6_o_r;
      dv_d_r[0]    <= s6_d_r;
      dv_cl_r[0]   <= s6_cl_r;
      dv_rej_r[0]  <= s6_rej_r;
      dv_sat_r[0]  <= (s6_tn_r >> SHW) >= s6_adet_r;
      dv_adet_r[0] <= s6_adet_r;
      dv_rem_r[0]  <= s6_tn_r >> SHW;
      dv_low_r[0]  <= DL'(s6_tn_r << FRAC_BITS);
      dv_q_r[0]    <= '0;

      for (int j = 0; j < NDIV; j++) begin
        dv_o_r[j+1]    <= dv_o_r[j];
        dv_d_r[j+1]    <= dv_d_r[j];
        dv_cl_r[j+1]   <= dv_cl_r[j];
        dv_rej_r[j+1]  <= dv_rej_r[j];
        dv_sat_r[j+1]  <= dv_sat_r[j];
        dv_adet_r[j+1] <= dv_adet_r[j];
        dv_rem_r[j+1]  <= take[j] ? (trial[j] - dv_adet_r[j]) : trial[j];
        dv_low_r[j+1]  <= dv_low_r[j] << 1;
        dv_q_r[j+1]    <= {dv_q_r[j][DL-2:0], take[j]};
      end

      sa_o_r    <= dv_o_r[NDIV];
      sa_miss_r <= miss_a;
      sa_t_r    <= tfix;
      for (int k = 0; k < 3; k++) begin
        sa_prod_r[k] <= $signed({1'b0, tfix}) * sa_d[k];
      end

      out_hit_r  <= !sa_miss_r;
      out_dist_r <= sa_miss_r ? '0 : sa_t_r;
      out_pt_r   <= sa_miss_r ? '0 : pt_pack;
      out_nrm_r  <= sa_miss_r ? '0 : normal_r;
    end
  end

  assign out_hit.valid        = out_v_r;
  assign out_hit.hit          = out_hit_r;
  assign out_hit.hit_distance = out_dist_r;
  assign out_hit.hit_point    = out_pt_r;
  assign out_hit.hit_normal   = out_nrm_r;

endmodule

/* rtl/core/rti_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks for the ray/triangle intersection block.
// ----------------------------------------------------------------------------
module rti_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_hit,
  input logic [rti_pkg::DIST_W-1:0] out_hit_distance,
  input logic [rti_pkg::VEC_W-1:0]  out_hit_point,
  input logic [rti_pkg::VEC_W-1:0]  out_hit_normal
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_hit_distance == '0) && (out_hit_point == '0) &&
                              (out_hit_normal == '0))
    else $error("miss carries nonzero payload");

  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_hit_distance != '0)
    else $error("hit with zero distance");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ray.ready),
  .out_valid        (out_hit.valid),
  .out_ready        (out_hit.ready),
  .out_hit          (out_hit.hit),
  .out_hit_distance (out_hit.hit_distance),
  .out_hit_point    (out_hit.hit_point),
  .out_hit_normal   (out_hit.hit_normal)
);
